### src/arm_reloc_pkg.sv
// shared types and encoding constants for the arm64 instruction relocator
// used by the front, the queue, the back and the top level
package arm_reloc_pkg;

   localparam logic [31:0] MASK_B26 = 32'h7C00_0000;
   localparam logic [31:0] OP_B     = 32'h1400_0000;
   localparam logic [31:0] OP_BL    = 32'h9400_0000;
   localparam logic [31:0] MASK_ADR = 32'h9F00_0000;
   localparam logic [31:0] OP_ADR   = 32'h1000_0000;
   localparam logic [31:0] OP_ADRP  = 32'h9000_0000;
   localparam logic [31:0] OP_MOVZ  = 32'hD280_0000;
   localparam logic [31:0] OP_MOVK  = 32'hF280_0000;
   localparam logic [31:0] OP_BR    = 32'hD61F_0000;
   localparam logic [31:0] OP_BLR   = 32'hD63F_0000;
   localparam logic [4:0]  SCRATCH_REG = 5'd17;
   localparam logic [63:0] PAGE_LOW = 64'hFFF;

   localparam logic CSR_SOURCE_BASE = 1'b0;
   localparam logic CSR_DEST_BASE   = 1'b1;

   typedef enum logic [1:0] {
      KIND_COPY,
      KIND_BRANCH,
      KIND_ADR,
      KIND_ADRP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        link;
      logic [4:0]  rd;
      logic [63:0] target;
      logic [31:0] insn;
      logic        fin;
   } item_type;

endpackage

### src/arm_reloc_front.sv
// front end: accepts instruction beats, classifies them and resolves the
// absolute target against the running source address; uses arm_reloc_pkg
module arm_reloc_front import arm_reloc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   input  logic        req_final_instruction,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item
);

   logic [63:0] source_pc_ff;
   logic [63:0] source_pc_in;
   logic [20:0] adr_raw;
   logic [63:0] adr_off;
   logic [63:0] base;
   logic [63:0] addend;
   kind_type    kind;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign adr_raw = {req_instruction[23:5], req_instruction[30:29]};
   assign adr_off = {{43{adr_raw[20]}}, adr_raw};

   always_comb begin
      base   = source_pc_ff;
      addend = 64'd0;
      if ((req_instruction & MASK_B26) == OP_B) begin
         kind   = KIND_BRANCH;
         addend = {{36{req_instruction[25]}}, req_instruction[25:0], 2'b00};
      end else if ((req_instruction & MASK_ADR) == OP_ADR) begin
         kind   = KIND_ADR;
         addend = adr_off;
      end else if ((req_instruction & MASK_ADR) == OP_ADRP) begin
         kind   = KIND_ADRP;
         base   = source_pc_ff & ~PAGE_LOW;
         addend = {adr_off[51:0], 12'b0};
      end else begin
         kind   = KIND_COPY;
      end
   end

   always_comb begin
      q_item.kind   = kind;
      q_item.link   = req_instruction[31];
      q_item.rd     = req_instruction[4:0];
      q_item.target = base + addend;
      q_item.insn   = req_instruction;
      q_item.fin    = req_final_instruction;
   end

   always_comb begin
      source_pc_in = source_pc_ff;
      if (q_push) begin
         source_pc_in = source_pc_ff + 64'd4;
      end
      if (csr_valid && csr_index == CSR_SOURCE_BASE) begin
         source_pc_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_pc_ff <= 64'd0;
      end else begin
         source_pc_ff <= source_pc_in;
      end
   end

endmodule

### src/arm_reloc_queue.sv
// two-entry queue of classified items between front and back
// uses item_type from arm_reloc_pkg
module arm_reloc_queue import arm_reloc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/arm_reloc_back.sv
// back end: range test against the running destination address, word
// emission and the registered result beat; uses arm_reloc_pkg
module arm_reloc_back import arm_reloc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_head,
   output logic        q_pop,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_word,
   output logic [63:0] rsp_out_address,
   output logic        rsp_run_last,
   output logic        rsp_block_done
);

   logic [63:0] dest_pc_ff;
   logic [63:0] dest_pc_in;
   logic [2:0]  k_ff;
   logic [2:0]  k_in;
   logic        long_ff;
   logic        long_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] word_ff;
   logic [63:0] addr_ff;
   logic        last_ff;
   logic        done_ff;

   logic        load;
   logic [63:0] delta;
   logic [63:0] dist_page;
   logic        fits;
   logic        long_now;
   logic        last;
   logic [31:0] word;
   logic [4:0]  mov_rd;

   function automatic logic [31:0] enc_adr_like(logic [31:0] op, logic [4:0] rd,
                                                logic [20:0] v);
      return op | {1'b0, v[1:0], 5'b0, v[20:2], rd};
   endfunction

   function automatic logic [31:0] enc_mov(logic [31:0] op, logic [4:0] rd,
                                           logic [63:0] addr, logic [1:0] hw);
      logic [15:0] part;
      part = addr[{hw, 4'b0} +: 16];
      return op | {9'b0, hw, part, rd};
   endfunction

   assign load      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign delta     = q_head.target - dest_pc_ff;
   assign dist_page = (q_head.target & ~PAGE_LOW) - (dest_pc_ff & ~PAGE_LOW);

   always_comb begin
      case (q_head.kind)
         KIND_BRANCH: fits = (delta[1:0] == 2'b00) &&
                             ((&delta[63:27]) || !(|delta[63:27]));
         KIND_ADR:    fits = (&delta[63:20]) || !(|delta[63:20]);
         KIND_ADRP:   fits = (&dist_page[63:32]) || !(|dist_page[63:32]);
         KIND_COPY:   fits = 1'b1;
         default:     fits = 1'b1;
      endcase
   end

   assign long_now = (k_ff == 3'd0) ? !fits : long_ff;
   assign mov_rd   = (q_head.kind == KIND_BRANCH) ? SCRATCH_REG : q_head.rd;

   always_comb begin
      if (!long_now) begin
         last = 1'b1;
      end else if (q_head.kind == KIND_BRANCH) begin
         last = (k_ff == 3'd4);
      end else begin
         last = (k_ff == 3'd3);
      end
   end

   always_comb begin
      word = q_head.insn;
      if (!long_now) begin
         case (q_head.kind)
            KIND_BRANCH: word = (q_head.link ? OP_BL : OP_B) | {6'b0, delta[27:2]};
            KIND_ADR:    word = enc_adr_like(OP_ADR, q_head.rd, delta[20:0]);
            KIND_ADRP:   word = enc_adr_like(OP_ADRP, q_head.rd, dist_page[32:12]);
            KIND_COPY:   word = q_head.insn;
            default:     word = q_head.insn;
         endcase
      end else if (k_ff == 3'd4) begin
         word = (q_head.link ? OP_BLR : OP_BR) | {22'b0, SCRATCH_REG, 5'b0};
      end else if (k_ff == 3'd0) begin
         word = enc_mov(OP_MOVZ, mov_rd, q_head.target, 2'd0);
      end else begin
         word = enc_mov(OP_MOVK, mov_rd, q_head.target, k_ff[1:0]);
      end
   end

   assign q_pop = load && last;

   always_comb begin
      dest_pc_in = dest_pc_ff;
      k_in       = k_ff;
      long_in    = long_ff;
      if (load) begin
         dest_pc_in = dest_pc_ff + 64'd4;
         k_in       = last ? 3'd0 : k_ff + 3'd1;
         long_in    = long_now;
      end
      if (csr_valid && csr_index == CSR_DEST_BASE) begin
         dest_pc_in = csr_data;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
         addr_ff <= dest_pc_ff;
         last_ff <= last;
         done_ff <= last && q_head.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_pc_ff   <= 64'd0;
         k_ff         <= 3'd0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dest_pc_ff   <= dest_pc_in;
         k_ff         <= k_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = word_ff;
   assign rsp_out_address = addr_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_block_done  = done_ff;

endmodule

### src/arm64_insn_relocator.sv
// top level of the arm64 instruction relocator
// instantiates arm_reloc_front, arm_reloc_queue and arm_reloc_back; uses arm_reloc_pkg
//
// Relocates a stream of AArch64 instruction words, one word per input beat,
// from the running source address to the running destination address. B, BL,
// ADR and ADRP are re-encoded when the new offset fits and otherwise expand to
// MOVZ plus three MOVK (and BR or BLR x17 for branches); everything else is
// copied. A word that stays one word is emitted alone, so such code streams at
// one instruction per cycle while the output does not stall; a long form emits
// its words in turn via the back end's single result register. A two-entry queue
// between the classifying front and the emitting back lets the input keep
// flowing while the output drains or stalls. Writing source_base or dest_base
// reloads the corresponding running address; the port is always ready.
module arm64_insn_relocator import arm_reloc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   input  logic        req_final_instruction,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_word,
   output logic [63:0] rsp_out_address,
   output logic        rsp_run_last,
   output logic        rsp_block_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type q_in_item;
   item_type q_head;

   assign csr_ready = 1'b1;

   arm_reloc_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_instruction       (req_instruction),
      .req_final_instruction (req_final_instruction),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_item                (q_in_item)
   );

   arm_reloc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   arm_reloc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_not_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_word    (rsp_out_word),
      .rsp_out_address (rsp_out_address),
      .rsp_run_last    (rsp_run_last),
      .rsp_block_done  (rsp_block_done)
   );

endmodule

### tb/arm64_insn_relocator_tb.sv
// self-checking testbench for arm64_insn_relocator: directed table, then random code streams
// needs arm_reloc_pkg and the arm64_insn_relocator rtl, nothing else
`timescale 1ns / 1ps

module arm64_insn_relocator_tb import arm_reloc_pkg::*; ();

   typedef struct packed {
      logic [31:0] word;
      logic [63:0] addr;
      logic        last;
      logic        done;
   } beat_type;

   typedef struct packed {
      logic        is_cfg;
      logic        idx;
      logic [63:0] data;
      logic [31:0] insn;
      logic        fin;
      logic        typed;
      logic [31:0] want;
   } dir_row_type;

   localparam int NROWS = 26;

   // at reset both running addresses are equal, so those rows come back unchanged
   localparam dir_row_type DIRECTED [NROWS] = '{
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1400_0000, 1'b0, 1'b1, 32'h1400_0000},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h15FF_FFFF, 1'b0, 1'b1, 32'h15FF_FFFF},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h9600_0000, 1'b0, 1'b1, 32'h9600_0000},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1000_0000, 1'b0, 1'b1, 32'h1000_0000},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h70FF_FFFF, 1'b0, 1'b1, 32'h70FF_FFFF},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h9080_0000, 1'b0, 1'b1, 32'h9080_0000},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'hF07F_FFFF, 1'b1, 1'b1, 32'hF07F_FFFF},
      '{1'b1, CSR_SOURCE_BASE, 64'h0000_0000_0040_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, CSR_DEST_BASE,   64'h0000_0000_0800_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1400_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h95FF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1600_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h9600_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1000_0003, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h9000_0011, 1'b1, 1'b0, 32'h0},
      '{1'b1, CSR_DEST_BASE,   64'h0000_0000_0800_0002, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1400_0010, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'hD503_201F, 1'b1, 1'b1, 32'hD503_201F},
      '{1'b1, CSR_SOURCE_BASE, 64'hFFFF_FFFF_FFFF_FFF8, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b1, CSR_DEST_BASE,   64'h0, 32'h0, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h1400_0004, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'hF0FF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h3000_0005, 1'b0, 1'b0, 32'h0},
      '{1'b0, CSR_SOURCE_BASE, 64'h0, 32'h9400_0001, 1'b1, 1'b0, 32'h0}
   };

   localparam logic [63:0] EXTREME_ADDR [4] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC, 64'h8000_0000_0000_0000
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instruction;
   logic        req_final_instruction;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_word;
   logic [63:0] rsp_out_address;
   logic        rsp_run_last;
   logic        rsp_block_done;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [63:0] csr_data;

   logic [63:0] src_pc;
   logic [63:0] dst_pc;
   beat_type    expected_beats [$];
   beat_type    head_beat;
   int          mismatch_count = 0;
   bit          no_idle = 1'b0;
   logic        row_typed = 1'b0;
   logic [31:0] row_word = '0;

   arm64_insn_relocator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_instruction       (req_instruction),
      .req_final_instruction (req_final_instruction),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_word          (rsp_out_word),
      .rsp_out_address       (rsp_out_address),
      .rsp_run_last          (rsp_run_last),
      .rsp_block_done        (rsp_block_done),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("arm64_insn_relocator_tb failed");
      $finish;
   end

   function automatic logic [31:0] adr_word(logic [31:0] op, logic [4:0] rd, logic [20:0] v);
      return op | {1'b0, v[1:0], 5'd0, v[20:2], rd};
   endfunction

   function automatic logic [31:0] mov_word(logic [4:0] rd, logic [63:0] addr, int hw);
      logic [31:0] op;
      logic [1:0]  sel;
      op = (hw == 0) ? OP_MOVZ : OP_MOVK;
      sel = 2'(hw);
      return op | {9'd0, sel, addr[16 * hw +: 16], rd};
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // rewrites one instruction for the current running addresses and queues its beats
   task automatic relocate_predict(logic [31:0] insn, logic fin, logic typed,
                                   logic [31:0] typed_word);
      logic [31:0] words [5];
      logic [63:0] imm;
      logic [63:0] off;
      logic [63:0] target;
      logic [63:0] delta;
      logic [4:0]  rd;
      logic [20:0] raw;
      int          n;
      beat_type    b;
      rd = insn[4:0];
      raw = {insn[23:5], insn[30:29]};
      off = {{43{raw[20]}}, raw};
      if ((insn & MASK_B26) == OP_B) begin
         imm = {{38{insn[25]}}, insn[25:0]};
         target = src_pc + (imm << 2);
         delta = target - dst_pc;
         if (delta[1:0] == 2'b00 && delta + (64'd1 << 27) < (64'd1 << 28)) begin
            words[0] = (insn[31] ? OP_BL : OP_B) | {6'd0, delta[27:2]};
            n = 1;
         end else begin
            for (int hw = 0; hw < 4; hw++) words[hw] = mov_word(SCRATCH_REG, target, hw);
            words[4] = (insn[31] ? OP_BLR : OP_BR) | {22'd0, SCRATCH_REG, 5'd0};
            n = 5;
         end
      end else if ((insn & MASK_ADR) == OP_ADRP) begin
         target = (src_pc & ~PAGE_LOW) + (off << 12);
         delta = (target & ~PAGE_LOW) - (dst_pc & ~PAGE_LOW);
         if (delta + (64'd1 << 32) < (64'd1 << 33)) begin
            words[0] = adr_word(OP_ADRP, rd, delta[32:12]);
            n = 1;
         end else begin
            for (int hw = 0; hw < 4; hw++) words[hw] = mov_word(rd, target, hw);
            n = 4;
         end
      end else if ((insn & MASK_ADR) == OP_ADR) begin
         target = src_pc + off;
         delta = target - dst_pc;
         if (delta + (64'd1 << 20) < (64'd1 << 21)) begin
            words[0] = adr_word(OP_ADR, rd, delta[20:0]);
            n = 1;
         end else begin
            for (int hw = 0; hw < 4; hw++) words[hw] = mov_word(rd, target, hw);
            n = 4;
         end
      end else begin
         words[0] = insn;
         n = 1;
      end
      if (typed) words[0] = typed_word;
      for (int k = 0; k < n; k++) begin
         b.word = words[k];
         b.addr = dst_pc + 64'(4 * k);
         b.last = (k == n - 1);
         b.done = (k == n - 1) && fin;
         expected_beats.push_back(b);
      end
      dst_pc = dst_pc + 64'(4 * n);
      src_pc = src_pc + 64'd4;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_pc = '0;
         dst_pc = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SOURCE_BASE) src_pc = csr_data;
            else dst_pc = csr_data;
         end
         if (req_valid && !req_stall)
            relocate_predict(req_instruction, req_final_instruction, row_typed, row_word);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with nothing pending", {32'd0, rsp_out_word}, '0);
            end else begin
               head_beat = expected_beats.pop_front();
               if (rsp_out_word !== head_beat.word)
                  report_mismatch("out_word", {32'd0, rsp_out_word}, {32'd0, head_beat.word});
               if (rsp_out_address !== head_beat.addr)
                  report_mismatch("out_address", rsp_out_address, head_beat.addr);
               if (rsp_run_last !== head_beat.last)
                  report_mismatch("run_last", {63'd0, rsp_run_last}, {63'd0, head_beat.last});
               if (rsp_block_done !== head_beat.done)
                  report_mismatch("block_done", {63'd0, rsp_block_done},
                                  {63'd0, head_beat.done});
            end
         end
      end
   end

   // result side back-pressure in bursts: free-running, light or heavy
   initial begin : rsp_pressure
      int mode;
      int len;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 9);
         len = $urandom_range(5, 40);
         repeat (len) begin
            @(negedge clock);
            if (mode < 3) rsp_stall = 1'b0;
            else if (mode == 9) rsp_stall = ($urandom_range(0, 5) != 0);
            else rsp_stall = ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] random_insn();
      logic [31:0] w;
      int r;
      w = $urandom;
      r = $urandom_range(0, 99);
      if (r < 30) w = (w & ~MASK_B26) | OP_B;
      else if (r < 42) w = (w & 32'h8000_0000) | OP_B | {6'd0, {18{w[7]}}, w[7:0]};
      else if (r < 67) w = (w & ~MASK_ADR) | (w[31] ? OP_ADRP : OP_ADR);
      return w;
   endfunction

   task automatic send_insn(logic [31:0] insn, logic fin, logic typed, logic [31:0] tword);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_instruction = insn;
      req_final_instruction = fin;
      row_typed = typed;
      row_word = tword;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      row_typed = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [63:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      dir_row_type row;
      logic [63:0] sbase;
      logic [63:0] dbase;
      logic [31:0] r;
      int          mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_instruction = '0;
      req_final_instruction = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SOURCE_BASE;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NROWS; i++) begin
         row = DIRECTED[i];
         if (row.is_cfg) begin
            wait_quiet();
            csr_write(row.idx, row.data);
         end else begin
            send_insn(row.insn, row.fin, row.typed, row.want);
         end
      end

      for (int p = 0; p < 8; p++) begin
         wait_quiet();
         no_idle = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 4);
         r = $urandom;
         sbase = {$urandom, $urandom};
         case (mode)
            0: dbase = sbase + ({{44{r[19]}}, r[19:0]} & ~64'd3);
            1: dbase = {$urandom, $urandom};
            2: dbase = sbase + (((r[0] ? 64'h0800_0000 : 64'hFFFF_FFFF_F800_0000)
                                 + {{56{r[15]}}, r[15:8]}) & ~64'd3);
            3: begin
               sbase = EXTREME_ADDR[$urandom_range(0, 3)];
               dbase = EXTREME_ADDR[$urandom_range(0, 3)];
            end
            default: dbase = sbase + ({{44{r[19]}}, r[19:2], 2'b00}
                                      | 64'($urandom_range(1, 3)));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            csr_write(CSR_DEST_BASE, dbase);
         end else if (r[31]) begin
            csr_write(CSR_SOURCE_BASE, sbase);
            csr_write(CSR_DEST_BASE, dbase);
         end else begin
            csr_write(CSR_DEST_BASE, dbase);
            csr_write(CSR_SOURCE_BASE, sbase);
         end
         for (int k = 0; k < 15; k++)
            send_insn(random_insn(), (k == 14) || ($urandom_range(0, 7) == 0), 1'b0, '0);
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("arm64_insn_relocator_tb passed");
      end else begin
         $display("arm64_insn_relocator_tb failed");
      end
      $finish;
   end

endmodule
